// File: sv/priority_round_robin_scheduler_macros.svh
// Assertion macros shared by the checker files.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PRRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

// File: sv/prrs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prrs_pkg
// Types, constants and helpers of the priority round robin scheduler.
// ---------------------------------------------------------------------------
package prrs_pkg;

	localparam int LEVELS_DEF    = 128;
	localparam int MAX_TASKS_DEF = 64;
	localparam int TOT_W         = 48;
	localparam int SRV_W         = 7;
	localparam logic [15:0] QUANTUM_RST = 16'd10;
	localparam logic [6:0]  ADDED_MAX   = 7'd127;

	// configuration register index (byte address bits above the word offset)
	localparam logic REG_QUANTUM = 1'b0;

	// result status codes
	localparam logic [1:0] ST_ADDED  = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_RAN    = 2'd2;
	localparam logic [1:0] ST_NONE   = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [15:0] task_tag;
		logic [6:0]  priority_req;
		logic [15:0] burst;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] ran_tag;
		logic [15:0] slice_length;
		logic        task_finished;
		logic [47:0] turnaround_total;
		logic [47:0] waiting_total;
		logic [47:0] response_total;
		logic [6:0]  tasks_added;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SRCH,
		S_LRD,
		S_HRD,
		S_EXEC,
		S_ACC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic add_rej;
		logic step_none;
		logic add_wr;
		logic srch;
		logic lvl_rd;
		logic ent_rd;
		logic exec;
		logic acc;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_step;
		logic full;
		logic empty;
	} ctl_sts_t;

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

endpackage

// File: sv/priority_round_robin_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_round_robin_scheduler
// Priority levels with round robin per level; quantum register on APB.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the word is taken at an edge
//   with start high and busy low. kind 0 adds a task, kind 1 runs a slice.
//   Result channel: done is high for one cycle with res; the receiver must
//   take it then, it cannot stall the block.
//   Sequence: a rejected add or a step with nothing queued answers in the
//   cycle after it is taken, an add reads the queue descriptor, then writes,
//   and a step walks the level search tree, descriptor read, task read,
//   slice update and totals. One word is in flight at a time.
//   The step sequence follows the chain of registered memory reads of the
//   level descriptor and the task entry.
//   Config: quantum at byte address 0; 0 acts as 1. The user must write it
//   only while idle; the block does not enforce it. Reset: all queues empty,
//   totals zero, quantum 10. No clearing pass is needed: level occupancy is
//   kept in flops and unused task slots are handed out from a fill count.
// ---------------------------------------------------------------------------
module priority_round_robin_scheduler #(
	parameter int LEVELS    = prrs_pkg::LEVELS_DEF,
	parameter int MAX_TASKS = prrs_pkg::MAX_TASKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  prrs_pkg::cmd_t cmd,
	output logic           done,
	output prrs_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [15:0]        quantum_q;
	prrs_pkg::ctl_cmd_t ctl;
	prrs_pkg::ctl_sts_t sts;

	// config register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= prrs_pkg::QUANTUM_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == prrs_pkg::REG_QUANTUM) begin
			quantum_q <= pwdata[15:0];
		end
	end
	assign prdata = (paddr[2] == prrs_pkg::REG_QUANTUM) ? {16'd0, quantum_q} : '0;

	prrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	prrs_dp #(
		.LEVELS    (LEVELS),
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd),
		.ctl     (ctl),
		.quantum (quantum_q),
		.sts     (sts),
		.done    (done),
		.res     (res)
	);

endmodule

// File: sv/prrs_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prrs_ctrl
// Sequencer: walks add and step words through the datapath.
// ---------------------------------------------------------------------------
module prrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  prrs_pkg::ctl_sts_t  sts,
	output prrs_pkg::ctl_cmd_t  ctl,
	output logic                busy
);

	prrs_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prrs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			prrs_pkg::S_IDLE: begin
				if (start) begin
					if (!sts.is_step && !sts.full) state_nxt = prrs_pkg::S_ADD;
					else if (sts.is_step && !sts.empty) state_nxt = prrs_pkg::S_SRCH;
				end
			end
			prrs_pkg::S_ADD:  state_nxt = prrs_pkg::S_IDLE;
			prrs_pkg::S_SRCH: state_nxt = prrs_pkg::S_LRD;
			prrs_pkg::S_LRD:  state_nxt = prrs_pkg::S_HRD;
			prrs_pkg::S_HRD:  state_nxt = prrs_pkg::S_EXEC;
			prrs_pkg::S_EXEC: state_nxt = prrs_pkg::S_ACC;
			prrs_pkg::S_ACC:  state_nxt = prrs_pkg::S_IDLE;
			default:          state_nxt = prrs_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		case (state_q)
			prrs_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.capture   = 1'b1;
					ctl.add_rej   = !sts.is_step && sts.full;
					ctl.step_none = sts.is_step && sts.empty;
				end
			end
			prrs_pkg::S_ADD:  ctl.add_wr = 1'b1;
			prrs_pkg::S_SRCH: ctl.srch   = 1'b1;
			prrs_pkg::S_LRD:  ctl.lvl_rd = 1'b1;
			prrs_pkg::S_HRD:  ctl.ent_rd = 1'b1;
			prrs_pkg::S_EXEC: ctl.exec   = 1'b1;
			prrs_pkg::S_ACC:  ctl.acc    = 1'b1;
			default:          busy = 1'b1;
		endcase
	end

endmodule

// File: sv/prrs_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prrs_dp
// Datapath: task store, level queues, free list, level search, totals.
// ---------------------------------------------------------------------------
module prrs_dp #(
	parameter int LEVELS    = prrs_pkg::LEVELS_DEF,
	parameter int MAX_TASKS = prrs_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prrs_pkg::cmd_t     cmd_in,
	input  prrs_pkg::ctl_cmd_t ctl,
	input  logic [15:0]        quantum,
	output prrs_pkg::ctl_sts_t sts,
	output logic               done,
	output prrs_pkg::res_t     res
);

	localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int GRP    = 16;
	localparam int GRP_W  = 4;
	localparam int NGRP   = (LEVELS + GRP - 1) / GRP;
	localparam int NG_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PROD_W = 16 + CNT_W;

	typedef struct packed {
		logic [IDX_W-1:0] head;
		logic [IDX_W-1:0] tail;
		logic [CNT_W-1:0] cnt;
	} lw_t;

	// memories
	logic [31:0]      ent_mem [MAX_TASKS];
	logic [IDX_W-1:0] nxt_mem [MAX_TASKS];
	lw_t              lvl_mem [LEVELS];
	logic [31:0]      ent_rd_q;
	logic [IDX_W-1:0] nxt_rd_q;
	lw_t              lvl_rd_q;

	logic             ent_we;
	logic [IDX_W-1:0] ent_wa;
	logic [31:0]      ent_wd;
	logic             nxt_we, nxt_re;
	logic [IDX_W-1:0] nxt_wa, nxt_wd, nxt_ra;
	logic             lvl_we, lvl_re;
	logic [LVL_W-1:0] lvl_wa, lvl_ra;
	lw_t              lvl_wd;

	// control state
	logic [LEVELS-1:0] ne_q;
	logic [IDX_W-1:0]  free_head_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  live_q;
	logic [6:0]        added_q;
	logic [47:0]       clock_q, turn_q, wait_q, resp_q;
	logic [LVL_W-1:0]  cur_lvl_q;
	logic [prrs_pkg::SRV_W-1:0] served_q;

	// captured word and scratch
	prrs_pkg::cmd_t    cmd_q;
	logic [LVL_W-1:0]  alvl_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [NGRP-1:0]   grp_any_s1;
	logic [GRP_W-1:0]  grp_loc_s1 [NGRP];
	logic [PROD_W-1:0] prod_q;

	// result registers
	logic              done_q;
	logic [1:0]        status_q;
	logic [15:0]       tag_q, slice_q;
	logic              fin_q;

	// combinational helpers
	logic [LVL_W-1:0]  prio_lvl;
	logic              fresh;
	logic [IDX_W-1:0]  fh_nxt;
	logic [15:0]       q_eff, rem, slice_c;
	logic              fin_c;
	logic [IDX_W-1:0]  e;
	logic [CNT_W-1:0]  cnt;
	logic [NGRP*GRP-1:0] ne_pad;
	logic [NGRP-1:0]   grp_any_c;
	logic [GRP_W-1:0]  grp_loc_c [NGRP];
	logic [NG_W-1:0]   grp_sel;
	logic [prrs_pkg::SRV_W-1:0] srv_c;

	assign sts.is_step = cmd_in.kind;
	assign sts.full    = (live_q == CNT_W'(MAX_TASKS));
	assign sts.empty   = (live_q == '0);

	// priority clamp
	always_comb begin
		if (32'(cmd_in.priority_req) >= LEVELS) prio_lvl = LVL_W'(LEVELS - 1);
		else prio_lvl = LVL_W'(cmd_in.priority_req);
	end

	// free list: untouched entries come from the fill count, freed ones are chained
	assign fresh  = (fill_q != CNT_W'(MAX_TASKS)) && (CNT_W'(free_head_q) == fill_q);
	assign fh_nxt = !fresh ? nxt_rd_q :
		(free_head_q == IDX_W'(MAX_TASKS - 1)) ? '0 : free_head_q + IDX_W'(1);

	// slice math
	assign q_eff   = (quantum == '0) ? 16'd1 : quantum;
	assign rem     = ent_rd_q[15:0];
	assign fin_c   = (rem <= q_eff);
	assign slice_c = fin_c ? rem : q_eff;
	assign e       = lvl_rd_q.head;
	assign cnt     = lvl_rd_q.cnt;

	// per-group highest nonempty level
	assign ne_pad = (NGRP*GRP)'(ne_q);
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any_c[g] = 1'b0;
			grp_loc_c[g] = '0;
			for (int i = 0; i < GRP; i++) begin
				if (ne_pad[g*GRP + i]) begin
					grp_any_c[g] = 1'b1;
					grp_loc_c[g] = GRP_W'(i);
				end
			end
		end
	end

	// highest nonempty group
	always_comb begin
		grp_sel = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_any_s1[g]) grp_sel = NG_W'(g);
		end
	end

	// served count after a level change
	assign srv_c = (lvl_q != cur_lvl_q) ? '0 : served_q;

	// memory write and read ports
	always_comb begin
		ent_we = 1'b0;
		ent_wa = e;
		ent_wd = {ent_rd_q[31:16], rem - slice_c};
		nxt_we = 1'b0;
		nxt_wa = lvl_rd_q.tail;
		nxt_wd = e;
		nxt_re = 1'b0;
		nxt_ra = free_head_q;
		lvl_we = 1'b0;
		lvl_wa = lvl_q;
		lvl_wd = lvl_rd_q;
		lvl_re = 1'b0;
		lvl_ra = prio_lvl;
		if (ctl.capture) begin
			nxt_re = 1'b1;
			lvl_re = 1'b1;
		end
		if (ctl.lvl_rd) begin
			lvl_re = 1'b1;
			lvl_ra = lvl_q;
		end
		if (ctl.ent_rd) begin
			nxt_re = 1'b1;
			nxt_ra = e;
		end
		if (ctl.add_wr) begin
			ent_we = 1'b1;
			ent_wa = free_head_q;
			ent_wd = {cmd_q.task_tag, cmd_q.burst};
			lvl_we = 1'b1;
			lvl_wa = alvl_q;
			if (ne_q[alvl_q]) begin
				nxt_we = 1'b1;
				nxt_wa = lvl_rd_q.tail;
				nxt_wd = free_head_q;
				lvl_wd = '{head: lvl_rd_q.head, tail: free_head_q, cnt: cnt + CNT_W'(1)};
			end else begin
				lvl_wd = '{head: free_head_q, tail: free_head_q, cnt: CNT_W'(1)};
			end
		end
		if (ctl.exec) begin
			lvl_we = 1'b1;
			if (fin_c) begin
				nxt_we = 1'b1;
				nxt_wa = e;
				nxt_wd = free_head_q;
				lvl_wd = '{head: nxt_rd_q, tail: lvl_rd_q.tail, cnt: cnt - CNT_W'(1)};
			end else begin
				ent_we = 1'b1;
				if (cnt > CNT_W'(1)) begin
					nxt_we = 1'b1;
					lvl_wd = '{head: nxt_rd_q, tail: e, cnt: cnt};
				end else begin
					lvl_wd = '{head: e, tail: e, cnt: CNT_W'(1)};
				end
			end
		end
	end

	// task store
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (ctl.ent_rd) ent_rd_q <= ent_mem[e];
	end

	// next links
	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (nxt_re) nxt_rd_q <= nxt_mem[nxt_ra];
	end

	// level queue descriptors
	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
		if (lvl_re) lvl_rd_q <= lvl_mem[lvl_ra];
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q      <= cmd_in;
			alvl_q     <= prio_lvl;
			grp_any_s1 <= grp_any_c;
			grp_loc_s1 <= grp_loc_c;
		end
		if (ctl.srch) lvl_q <= LVL_W'({grp_sel, grp_loc_s1[grp_sel]});
		if (ctl.exec) prod_q <= PROD_W'(slice_c) * PROD_W'(live_q - CNT_W'(1));
	end

	// scheduler state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q        <= '0;
			free_head_q <= '0;
			fill_q      <= '0;
			live_q      <= '0;
			added_q     <= '0;
			clock_q     <= '0;
			turn_q      <= '0;
			wait_q      <= '0;
			resp_q      <= '0;
			cur_lvl_q   <= '0;
			served_q    <= '0;
		end else begin
			if (ctl.add_wr) begin
				ne_q[alvl_q] <= 1'b1;
				free_head_q  <= fh_nxt;
				if (fresh) fill_q <= fill_q + CNT_W'(1);
				live_q <= live_q + CNT_W'(1);
				if (added_q != prrs_pkg::ADDED_MAX) added_q <= added_q + 7'd1;
			end
			if (ctl.exec) begin
				clock_q   <= prrs_pkg::sat_add48(clock_q, 48'(slice_c));
				cur_lvl_q <= lvl_q;
				if (32'(srv_c) < 32'(cnt)) begin
					resp_q   <= prrs_pkg::sat_add48(resp_q, clock_q);
					served_q <= (srv_c != '1) ? srv_c + prrs_pkg::SRV_W'(1) : srv_c;
				end else begin
					served_q <= srv_c;
				end
				if (fin_c) begin
					free_head_q <= e;
					live_q      <= live_q - CNT_W'(1);
					if (cnt == CNT_W'(1)) ne_q[lvl_q] <= 1'b0;
				end
			end
			if (ctl.acc) begin
				wait_q <= prrs_pkg::sat_add48(wait_q, 48'(prod_q));
				if (fin_q) turn_q <= prrs_pkg::sat_add48(turn_q, clock_q);
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.add_rej || ctl.step_none || ctl.add_wr || ctl.acc;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (ctl.add_rej || ctl.step_none || ctl.add_wr) begin
			tag_q   <= '0;
			slice_q <= '0;
			fin_q   <= 1'b0;
		end
		if (ctl.add_rej)   status_q <= prrs_pkg::ST_REJECT;
		if (ctl.step_none) status_q <= prrs_pkg::ST_NONE;
		if (ctl.add_wr)    status_q <= prrs_pkg::ST_ADDED;
		if (ctl.exec) begin
			status_q <= prrs_pkg::ST_RAN;
			tag_q    <= ent_rd_q[31:16];
			slice_q  <= slice_c;
			fin_q    <= fin_c;
		end
	end

	assign done                 = done_q;
	assign res.status           = status_q;
	assign res.ran_tag          = tag_q;
	assign res.slice_length     = slice_q;
	assign res.task_finished    = fin_q;
	assign res.turnaround_total = turn_q;
	assign res.waiting_total    = wait_q;
	assign res.response_total   = resp_q;
	assign res.tasks_added      = added_q;

endmodule

// File: sv/prrs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prrs_props
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "priority_round_robin_scheduler_macros.svh"

module prrs_props (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input prrs_pkg::cmd_t cmd,
	input logic           done,
	input prrs_pkg::res_t res
);

	// a result is only given once the sequencer is back at rest
	`PRRS_ASSERT_IMP(a_done_idle, done, !busy)

	// an accepted word either answers at once or keeps the block busy
	`PRRS_ASSERT_NXT(a_accept_progress, start && !busy, done || busy)

	// only a slice carries tag, length and finish flag
	`PRRS_ASSERT_IMP(a_no_slice_fields, done && res.status != prrs_pkg::ST_RAN,
		res.ran_tag == '0 && res.slice_length == '0 && !res.task_finished)

	// an accepted add always leaves a nonzero add count
	`PRRS_ASSERT_IMP(a_add_count, done && res.status == prrs_pkg::ST_ADDED,
		res.tasks_added != '0)

endmodule

bind priority_round_robin_scheduler prrs_props u_prrs_props (.*);
